[rtl/core/magnetic_heading_direction_match_assert.svh]
// Assertion macros shared by the heading block.
`ifndef MAGNETIC_HEADING_DIRECTION_MATCH_ASSERT_SVH
`define MAGNETIC_HEADING_DIRECTION_MATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHDM_ASSERT_NOW(label, clk_i, rstn_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error("heading block: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MHDM_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error("heading block: check failed");

`endif

[rtl/core/mhdm_pkg.sv]
// Constants, types and angle table for the magnetometer heading block.
package mhdm_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int LATENCY       = CORDIC_STAGES + 4;

	localparam int CW = 32;   // CORDIC X/Y datapath width
	localparam int ZW = 26;   // angle accumulator, 2^-16 degree

	localparam int FULL_TURN   = 23040;
	localparam int HALF_TURN   = 11520;
	localparam int EIGHTH_TURN = 2880;

	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * 65536);

	localparam logic signed [14:0] DECL_RESET = -15'sd549;
	localparam logic        [11:0] TOL_RESET  = 12'd640;

	typedef enum logic {
		REG_DECL = 1'b0,
		REG_TOL  = 1'b1
	} reg_idx_t;

	typedef logic [2:0] dir_t;

	// round(atan(2^-i) * 65536), degrees
	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0:       a = ZW'(2949120);
			1:       a = ZW'(1740967);
			2:       a = ZW'(919879);
			3:       a = ZW'(466945);
			4:       a = ZW'(234379);
			5:       a = ZW'(117304);
			6:       a = ZW'(58666);
			7:       a = ZW'(29335);
			8:       a = ZW'(14668);
			9:       a = ZW'(7334);
			10:      a = ZW'(3667);
			11:      a = ZW'(1833);
			12:      a = ZW'(917);
			13:      a = ZW'(458);
			14:      a = ZW'(229);
			15:      a = ZW'(115);
			16:      a = ZW'(57);
			17:      a = ZW'(29);
			18:      a = ZW'(14);
			19:      a = ZW'(7);
			20:      a = ZW'(4);
			21:      a = ZW'(2);
			22:      a = ZW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	// window centre, 45 degrees per direction step
	function automatic logic signed [16:0] dir_centre(input dir_t d);
		logic signed [16:0] c;
		case (d)
			3'd0:    c = 17'sd0;
			3'd1:    c = 17'(EIGHTH_TURN * 1);
			3'd2:    c = 17'(EIGHTH_TURN * 2);
			3'd3:    c = 17'(EIGHTH_TURN * 3);
			3'd4:    c = 17'(EIGHTH_TURN * 4);
			3'd5:    c = 17'(EIGHTH_TURN * 5);
			3'd6:    c = 17'(EIGHTH_TURN * 6);
			3'd7:    c = 17'(EIGHTH_TURN * 7);
			default: c = 17'sd0;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/magnetic_heading_direction_match.sv]
// Compass heading from a magnetometer X/Y pair with direction window match.
//
//  channel   | signals                          | transfer when
//  ----------+----------------------------------+------------------------
//  input     | mag_x, mag_y, direction          | start high, busy low
//  result    | heading, match                   | valid high (one cycle)
//  config    | cfg_idx, cfg_data                | cfg_we high
//
// One item may enter every cycle; busy never rises.
// From the start edge to the valid cycle an item passes through these registers:
// one pre-rotation stage, one register per CORDIC micro-rotation, then
// declination subtract, wrap into [0,360) and window compare.
// arst_n clears the valid bits and reloads declination and tolerance.
// The receiver cannot stall; results leave on valid regardless.
`include "magnetic_heading_direction_match_assert.svh"

module magnetic_heading_direction_match (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  mag_x,
	input  logic signed [15:0]  mag_y,
	input  mhdm_pkg::dir_t      direction,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [14:0]         cfg_data,
	output logic                valid,
	output logic [14:0]         heading,
	output logic                match
);
	import mhdm_pkg::*;

	// configuration
	logic signed [14:0] decl_q;
	logic        [11:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_RESET;
			tol_q  <= TOL_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_DECL: decl_q <= $signed(cfg_data);
				REG_TOL:  tol_q  <= cfg_data[11:0];
				default:  ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---- pre-rotation: vector (-mag_y, -mag_x) scaled by 4096 ----
	logic signed [16:0]    px, py;
	logic signed [CW-1:0]  xin, yin, xpre, ypre;
	logic signed [ZW-1:0]  zpre;

	assign px  = -$signed({mag_y[15], mag_y});
	assign py  = -$signed({mag_x[15], mag_x});
	assign xin = {{(CW-29){px[16]}}, px, 12'b0};
	assign yin = {{(CW-29){py[16]}}, py, 12'b0};

	always_comb begin
		xpre = xin;
		ypre = yin;
		zpre = '0;
		if (xin[CW-1]) begin
			if (!yin[CW-1]) begin
				xpre = yin;
				ypre = -xin;
				zpre = Z_QUARTER;
			end else begin
				xpre = -yin;
				ypre = xin;
				zpre = -Z_QUARTER;
			end
		end
	end

	// stage k holds the vector after k micro-rotations
	logic                 vld_s [0:CORDIC_STAGES];
	logic signed [CW-1:0] x_s   [0:CORDIC_STAGES];
	logic signed [CW-1:0] y_s   [0:CORDIC_STAGES];
	logic signed [ZW-1:0] z_s   [0:CORDIC_STAGES];
	logic                 spc_s [0:CORDIC_STAGES];  // Y reading zero
	logic                 xps_s [0:CORDIC_STAGES];  // mag_x positive
	dir_t                 dir_s [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			x_s[0]   <= xpre;
			y_s[0]   <= ypre;
			z_s[0]   <= zpre;
			spc_s[0] <= (mag_y == 16'sd0);
			xps_s[0] <= ~mag_x[15] & (mag_x != 16'sd0);
			dir_s[0] <= direction;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		logic signed [CW-1:0] dx, dy;
		logic                 cw;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign cw = ~y_s[i][CW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[i]) begin
				x_s[i+1]   <= cw ? x_s[i] + dx : x_s[i] - dx;
				y_s[i+1]   <= cw ? y_s[i] - dy : y_s[i] + dy;
				z_s[i+1]   <= cw ? z_s[i] + atan_step(i) : z_s[i] - atan_step(i);
				spc_s[i+1] <= spc_s[i];
				xps_s[i+1] <= xps_s[i];
				dir_s[i+1] <= dir_s[i];
			end
		end
	end

	// ---- round to 1/64 degree, pick the special case, subtract declination ----
	logic signed [ZW-1:0] zr;
	logic signed [16:0]   hsel;
	logic                 vld_v_q;
	logic signed [16:0]   v_q;
	dir_t                 dir_v_q;

	assign zr = z_s[CORDIC_STAGES] + ZW'(512);

	always_comb begin
		if (spc_s[CORDIC_STAGES]) begin
			hsel = xps_s[CORDIC_STAGES] ? 17'(HALF_TURN) : 17'sd0;
		end else begin
			hsel = {zr[ZW-1], zr[ZW-1:10]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_v_q <= 1'b0;
		end else begin
			vld_v_q <= vld_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[CORDIC_STAGES]) begin
			v_q     <= hsel - {{2{decl_q[14]}}, decl_q};
			dir_v_q <= dir_s[CORDIC_STAGES];
		end
	end

	// ---- wrap into 0..FULL_TURN-1 ----
	logic signed [17:0] vw, va, vb, vc, hw;
	logic               vld_h_q;
	logic [14:0]        h_q;
	dir_t               dir_h_q;

	assign vw = {v_q[16], v_q};
	assign va = vw + 18'(FULL_TURN);
	assign vb = vw + 18'(2 * FULL_TURN);
	assign vc = vw - 18'(FULL_TURN);

	always_comb begin
		if (vw[17]) begin
			hw = va[17] ? vb : va;
		end else if (vw >= 18'(FULL_TURN)) begin
			hw = vc;
		end else begin
			hw = vw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_h_q <= 1'b0;
		end else begin
			vld_h_q <= vld_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_v_q) begin
			h_q     <= hw[14:0];
			dir_h_q <= dir_v_q;
		end
	end

	// ---- window compare, result register ----
	logic signed [16:0] hs, ts, cen;
	logic               hit;

	assign hs  = {2'b00, h_q};
	assign ts  = {5'b0, tol_q};
	assign cen = dir_centre(dir_h_q);

	always_comb begin
		if (dir_h_q == 3'd0) begin
			// north wraps round through zero; exactly zero misses
			hit = ((h_q != 15'd0) && (hs < ts)) || (hs > 17'(FULL_TURN) - ts);
		end else begin
			hit = (hs > cen - ts) && (hs < cen + ts);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= vld_h_q;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_h_q) begin
			heading <= h_q;
			match   <= hit;
		end
	end

	// ---- checks ----
	`MHDM_ASSERT_NOW(a_head_range, clk, arst_n, valid, heading < 15'(FULL_TURN))
	`MHDM_ASSERT_NOW(a_no_orphan, clk, arst_n, valid, $past(start, LATENCY))
	`MHDM_ASSERT_NEXT(a_wrap_range, clk, arst_n, vld_v_q, h_q < 15'(FULL_TURN))
	`MHDM_ASSERT_NOW(a_north_zero, clk, arst_n,
		vld_h_q && (dir_h_q == 3'd0) && (h_q == 15'd0), !hit)

endmodule

[sim/magnetic_heading_direction_match_test.sv]
// Self-checking testbench for the magnetometer heading and direction match block.
module magnetic_heading_direction_match_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mhdm_pkg::*;

	typedef struct packed {
		logic signed [15:0] mx;
		logic signed [15:0] my;
		dir_t               dir;
		logic [14:0]        heading;
		logic               match;
	} heading_exp_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] mag_x;
	logic signed [15:0] mag_y;
	dir_t               direction;
	logic               cfg_we;
	logic               cfg_idx;
	logic [14:0]        cfg_data;
	logic               valid;
	logic [14:0]        heading;
	logic               match;

	magnetic_heading_direction_match dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.direction (direction),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.valid     (valid),
		.heading   (heading),
		.match     (match)
	);

	// round(atan(2^-i) * 65536) in degrees
	longint atan_deg16 [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	longint       decl_q;
	longint       tol_q;
	heading_exp_t heading_q [$];
	int           n_sent;
	int           n_results;
	int           n_hits;
	int           n_fail;
	int           n_writes;
	int           burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Timeout: %0d results still outstanding", heading_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic heading_exp_t predict_heading(input logic signed [15:0] mx,
			input logic signed [15:0] my, input dir_t d);
		heading_exp_t e;
		longint x, y, z, t, dx, dy, a, h, c;
		bit m;
		e.mx  = mx;
		e.my  = my;
		e.dir = d;
		if (my == 0) begin
			h = (mx > 0) ? HALF_TURN : 0;
		end else begin
			// vector is (-my, -mx), scaled by 4096
			x = -longint'(my) * 4096;
			y = -longint'(mx) * 4096;
			z = 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = 90 * 65536;
				end else begin
					t = x; x = -y; y = t; z = -90 * 65536;
				end
			end
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				a  = (i < 24) ? atan_deg16[5'(i)] : 0;
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += a;
				end else begin
					x -= dx; y += dy; z -= a;
				end
			end
			h = (z + 512) >>> 10;
		end
		h = (h - decl_q) % FULL_TURN;
		if (h < 0)
			h += FULL_TURN;
		if (d == 3'd0) begin
			m = (h > 0 && h < tol_q) || (h > FULL_TURN - tol_q);
		end else begin
			c = longint'(EIGHTH_TURN) * longint'(d);
			m = (h > c - tol_q) && (h < c + tol_q);
		end
		e.heading = h[14:0];
		e.match   = m;
		return e;
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start     = 1'b0;
			mag_x     = 16'($urandom);
			mag_y     = 16'($urandom);
			direction = 3'($urandom);
		end
	endtask

	task automatic send_sample(input logic signed [15:0] mx, input logic signed [15:0] my,
			input dir_t d);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 7));
		end
		burst_left--;
		@(negedge clk);
		start     = 1'b1;
		mag_x     = mx;
		mag_y     = my;
		direction = d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		heading_q.push_back(predict_heading(mx, my, d));
		n_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (heading_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [14:0] data);
		drain_results();
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		if (idx == REG_DECL)
			decl_q = longint'($signed(data));
		else
			tol_q = longint'(data[11:0]);
		n_writes++;
		@(negedge clk);
		cfg_we   = 1'b0;
		cfg_data = 15'($urandom);
	endtask

	task automatic random_sample(output logic signed [15:0] mx, output logic signed [15:0] my,
			output dir_t d);
		logic signed [15:0] pick [5] = '{-16'sd32768, 16'sd32767, -16'sd1, 16'sd0, 16'sd1};
		case ($urandom_range(0, 9))
			0: begin mx = 16'($urandom); my = 16'sd0; end
			1: begin mx = 16'sd0; my = 16'($urandom); end
			2: begin
				mx = $signed(16'($urandom_range(0, 16))) - 16'sd8;
				my = $signed(16'($urandom_range(0, 16))) - 16'sd8;
			end
			3: begin
				mx = pick[3'($urandom_range(0, 4))];
				my = pick[3'($urandom_range(0, 4))];
			end
			default: begin mx = 16'($urandom); my = 16'($urandom); end
		endcase
		d = 3'($urandom_range(0, 7));
	endtask

	// cardinal and diagonal vectors, a zero vector and one off-axis vector, under the reset declination and tolerance
	task automatic test_reset_config();
		send_sample(16'sd0, 16'sd0, 3'd0);
		send_sample(16'sd100, 16'sd0, 3'd4);
		send_sample(16'sd0, -16'sd100, 3'd0);
		send_sample(16'sd0, 16'sd100, 3'd4);
		send_sample(-16'sd100, 16'sd0, 3'd2);
		send_sample(-16'sd700, -16'sd700, 3'd1);
		send_sample(16'sd700, -16'sd700, 3'd7);
		send_sample(16'sd700, 16'sd700, 3'd5);
		send_sample(-16'sd700, 16'sd700, 3'd3);
		send_sample(16'sd3, -16'sd5, 3'd6);
	endtask

	task automatic test_field_extremes();
		send_sample(-16'sd32768, -16'sd32768, 3'd7);
		send_sample(16'sd32767, 16'sd32767, 3'd3);
		send_sample(-16'sd32768, 16'sd32767, 3'd1);
		send_sample(16'sd32767, -16'sd32768, 3'd5);
		send_sample(-16'sd32768, 16'sd0, 3'd2);
		send_sample(16'sd32767, 16'sd0, 3'd6);
		send_sample(16'sd0, -16'sd32768, 3'd0);
		send_sample(16'sd1, -16'sd1, 3'd4);
	endtask

	// y = 0 gives an exact heading, so declination steers it onto window limits
	task automatic test_window_bounds();
		write_reg(REG_TOL, 15'd2880);
		write_reg(REG_DECL, 15'd0);
		send_sample(16'sd0, 16'sd0, 3'd0);
		send_sample(16'sd5, 16'sd0, 3'd3);
		send_sample(16'sd5, 16'sd0, 3'd5);
		send_sample(16'sd5, 16'sd0, 3'd4);
		write_reg(REG_DECL, 15'h7FFF);
		send_sample(16'sd0, 16'sd0, 3'd0);
		write_reg(REG_DECL, 15'd1);
		send_sample(16'sd0, 16'sd0, 3'd0);
		send_sample(16'sd0, 16'sd0, 3'd7);
	endtask

	task automatic test_random_configs();
		logic signed [15:0] mx, my;
		dir_t               d;
		logic [14:0]        dv;
		logic [11:0]        tv;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin dv = 15'(-549);   tv = 12'd640;  end
				1: begin dv = 15'h4000;    tv = 12'd0;    end
				2: begin dv = 15'h3FFF;    tv = 12'd4095; end
				3: begin dv = 15'd11520;   tv = 12'd2880; end
				4: begin dv = 15'(-11520); tv = 12'd1;    end
				default: begin dv = 15'($urandom); tv = 12'($urandom); end
			endcase
			write_reg(REG_DECL, dv);
			// upper data bits are outside the tolerance register
			write_reg(REG_TOL, {3'($urandom), tv});
			for (int k = 0; k < 115; k++) begin
				if (ph == 2 && k == 50)
					drain_results();
				random_sample(mx, my, d);
				send_sample(mx, my, d);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		heading_exp_t e;
		if (arst_n && valid) begin
			n_results++;
			if (heading_q.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("Unexpected result: heading %0d match %0b", heading, match);
			end else begin
				e = heading_q.pop_front();
				if (heading !== e.heading || match !== e.match) begin
					n_fail++;
					if (n_fail <= 10)
						$display("Mismatch x=%0d y=%0d dir=%0d: heading %0d/%0d match %0b/%0b",
							e.mx, e.my, e.dir, e.heading, heading, e.match, match);
				end
				if (match === 1'b1)
					n_hits++;
			end
		end
	end

	initial begin
		int waited;
		arst_n     = 1'b0;
		start      = 1'b0;
		mag_x      = '0;
		mag_y      = '0;
		direction  = '0;
		cfg_we     = 1'b0;
		cfg_idx    = REG_DECL;
		cfg_data   = '0;
		decl_q     = -549;
		tol_q      = 640;
		n_sent     = 0;
		n_results  = 0;
		n_hits     = 0;
		n_fail     = 0;
		n_writes   = 0;
		burst_left = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_field_extremes();
		test_window_bounds();
		test_random_configs();

		@(negedge clk);
		start  = 1'b0;
		waited = 0;
		while (heading_q.size() != 0 && waited < 20 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		if (heading_q.size() != 0) begin
			n_fail++;
			$display("%0d expected results never arrived", heading_q.size());
		end
		repeat (LATENCY + 4) @(posedge clk);

		$display("Sent %0d samples, checked %0d headings, %0d in window, %0d register writes",
			n_sent, n_results, n_hits, n_writes);
		$display("Covered field extremes, y = 0 cases, window limits, all directions, %0d failures",
			n_fail);
		if (n_fail == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
